/* rtl/lifrk4_pkg.sv */
// ----------------------------------------------------------------------------
// lifrk4_pkg
// shared widths, codes, controller/datapath structs and arithmetic helpers
// ----------------------------------------------------------------------------
package lifrk4_pkg;

    localparam int SAMPLE_WIDTH  = 24;
    localparam int VOLTAGE_WIDTH = 32;

    localparam int LEAK_W    = 24;
    localparam int GAIN_W    = 32;
    localparam int THRESH_W  = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W    = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_LEAK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;

    localparam logic [LEAK_W-1:0]          LEAK_RESET   = 24'd335544;
    localparam logic [GAIN_W-1:0]          GAIN_RESET   = 32'd0;
    localparam logic signed [THRESH_W-1:0] THRESH_RESET = 32'sd7784628;

    // shared multiplier operands
    localparam int MUL_A_W = (SAMPLE_WIDTH > VOLTAGE_WIDTH) ? SAMPLE_WIDTH : VOLTAGE_WIDTH;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // derivative term widths
    localparam int P_BITS  = SAMPLE_WIDTH + GAIN_W + 1;
    localparam int Q_BITS  = VOLTAGE_WIDTH + LEAK_W;
    localparam int DIFF_W  = ((P_BITS > Q_BITS) ? P_BITS : Q_BITS) + 1;
    localparam int K_W     = DIFF_W - FRAC_W;
    localparam int SUM_W   = K_W + 3;

    // nibble-serial divide by six of the weighted sum magnitude
    localparam int DIGIT_W     = 4;
    localparam int DIV_DIGITS  = (SUM_W - 1 + DIGIT_W - 1) / DIGIT_W;
    localparam int MAG_W       = DIGIT_W * DIV_DIGITS;
    localparam int DIV_CNT_W   = $clog2(DIV_DIGITS);
    localparam int REM_W       = 3;
    localparam int DIG_VAL_W   = REM_W + DIGIT_W;
    localparam int RK4_DIVISOR = 6;

    localparam int SAT_A   = (K_W > MAG_W + 1) ? K_W : MAG_W + 1;
    localparam int SAT_W   = ((SAT_A > VOLTAGE_WIDTH) ? SAT_A : VOLTAGE_WIDTH) + 1;

    localparam logic signed [SAT_W-1:0] SAT_MAX =
        SAT_W'((longint'(1) <<< (VOLTAGE_WIDTH - 1)) - longint'(1));
    localparam logic signed [SAT_W-1:0] SAT_MIN = ~SAT_MAX;

    // current select codes
    localparam logic [1:0] SEL_PREV = 2'd0;
    localparam logic [1:0] SEL_MID  = 2'd1;
    localparam logic [1:0] SEL_NEW  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul_p;
        logic       mul_q;
        logic       x_use_v;
        logic [1:0] s_sel;
        logic       k_calc;
        logic       acc_upd;
        logic       acc_first;
        logic       k_dbl;
        logic       x_upd;
        logic       x_half;
        logic       div_init;
        logic       div_step;
        logic       finish;
        logic       finish_step;
    } lifrk4_cmd_t;

    typedef struct packed {
        logic have_prev;
        logic out_free;
    } lifrk4_status_t;

    function automatic logic signed [VOLTAGE_WIDTH-1:0] sat_volt(
        input logic signed [SAT_W-1:0] a);
        logic signed [SAT_W-1:0] r;
        if (a > SAT_MAX)
            r = SAT_MAX;
        else if (a < SAT_MIN)
            r = SAT_MIN;
        else
            r = a;
        return VOLTAGE_WIDTH'(r);
    endfunction

    function automatic logic [DIGIT_W-1:0] div6_digit(input logic [DIG_VAL_W-1:0] val);
        logic [DIGIT_W-1:0] d;
        d = '0;
        for (int i = 1; i < (1 << DIGIT_W); i++)
        begin
            if (val >= DIG_VAL_W'(RK4_DIVISOR * i))
                d = DIGIT_W'(i);
        end
        return d;
    endfunction

endpackage

/* rtl/lifrk4_ctrl.sv */
// ----------------------------------------------------------------------------
// lifrk4_ctrl
// sequencer: loads each word; a stepping word gets four derivative evaluations on one multiplier, then divide by six
// ----------------------------------------------------------------------------
module lifrk4_ctrl
    import lifrk4_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  lifrk4_status_t status,
    output lifrk4_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MP   = 3'd1;
    localparam logic [2:0] ST_MQ   = 3'd2;
    localparam logic [2:0] ST_KD   = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_PREP = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    localparam logic [1:0] LAST_STAGE = 2'd3;

    logic [2:0]           state_reg, state_next;
    logic [1:0]           stage_reg, stage_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [1:0] sel_for(input logic [1:0] stage);
        logic [1:0] s;
        if (stage == 2'd0)
            s = SEL_PREV;
        else if (stage == LAST_STAGE)
            s = SEL_NEW;
        else
            s = SEL_MID;
        return s;
    endfunction

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        stage_next = stage_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                stage_next = 2'd0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.have_prev ? ST_MP : ST_FIN;
                end
            end
            ST_MP:
            begin
                cmd.mul_p  = 1'b1;
                cmd.s_sel  = sel_for(stage_reg);
                state_next = ST_MQ;
            end
            ST_MQ:
            begin
                cmd.mul_q   = 1'b1;
                cmd.x_use_v = (stage_reg == 2'd0);
                state_next  = ST_KD;
            end
            ST_KD:
            begin
                cmd.k_calc = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.acc_upd   = 1'b1;
                cmd.acc_first = (stage_reg == 2'd0);
                cmd.k_dbl     = (stage_reg == 2'd1) || (stage_reg == 2'd2);
                if (stage_reg != LAST_STAGE)
                begin
                    // next derivative's current product overlaps the update
                    cmd.x_upd  = 1'b1;
                    cmd.x_half = (stage_reg != 2'd2);
                    cmd.mul_p  = 1'b1;
                    cmd.s_sel  = sel_for(stage_reg + 2'd1);
                    stage_next = stage_reg + 2'd1;
                    state_next = ST_MQ;
                end
                else
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_DIGITS - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.finish      = 1'b1;
                    cmd.finish_step = status.have_prev;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stage_reg <= 2'd0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("accepted word did not start processing");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> status.out_free)
        else $error("result written while output register still occupied");

    a_mult_shared: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mul_p && cmd.mul_q))
        else $error("multiplier claimed twice in one cycle");

    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !in_stall)
        else $error("not ready for a new word after finishing");
`endif

endmodule

/* rtl/lifrk4_datapath.sv */
// ----------------------------------------------------------------------------
// lifrk4_datapath
// config registers, neuron state, shared multiplier, rk4 accumulate, divide by six
// ----------------------------------------------------------------------------
module lifrk4_datapath
    import lifrk4_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [CFG_IDX_W-1:0]            cfg_index,
    input  logic [CFG_W-1:0]                cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0]  current_sample,
    input  logic                            last_of_trace,
    input  lifrk4_cmd_t                     cmd,
    output lifrk4_status_t                  status,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic                            spike,
    output logic signed [VOLTAGE_WIDTH-1:0] membrane_voltage
);

    logic [LEAK_W-1:0]          leak_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic signed [THRESH_W-1:0] thresh_reg;

    logic signed [VOLTAGE_WIDTH-1:0] volt_reg, volt_next;
    logic signed [SAMPLE_WIDTH-1:0]  prev_reg;
    logic                            have_prev_reg;
    logic                            out_valid_reg;

    logic signed [SAMPLE_WIDTH-1:0]  cur_reg, mid_reg, mid_next, s_mul;
    logic                            last_reg;
    logic signed [SAMPLE_WIDTH:0]    pair_sum;

    logic signed [VOLTAGE_WIDTH-1:0] x_reg, x_mul;
    logic signed [MUL_A_W-1:0]       mul_a;
    logic signed [MUL_B_W-1:0]       mul_b;
    logic signed [PROD_W-1:0]        prod;
    logic signed [DIFF_W-1:0]        p_reg, q_reg, diff;
    logic signed [K_W-1:0]           k_reg, k_next, k_half;
    logic signed [SAT_W-1:0]         x_sum, fin_sum;
    logic signed [SUM_W-1:0]         acc_reg, acc_add, acc_base;

    logic [SUM_W-1:0]                abs_acc;
    logic [MAG_W-1:0]                mag_reg, quo_reg;
    logic [REM_W-1:0]                rem_reg, rem_next;
    logic                            neg_reg;
    logic [DIG_VAL_W-1:0]            dig_val, dig_prod;
    logic [DIGIT_W-1:0]              dig;
    logic signed [MAG_W:0]           quo_s;

    logic signed [VOLTAGE_WIDTH-1:0] v_new;
    logic                            v_spike;
    logic                            out_spike_reg;
    logic signed [VOLTAGE_WIDTH-1:0] out_volt_reg;

    // midpoint current, floor of the average
    assign pair_sum = (SAMPLE_WIDTH + 1)'(prev_reg) + (SAMPLE_WIDTH + 1)'(current_sample);
    assign mid_next = SAMPLE_WIDTH'(pair_sum >>> 1);

    always_comb
    begin
        unique case (cmd.s_sel)
            SEL_PREV: s_mul = prev_reg;
            SEL_MID:  s_mul = mid_reg;
            SEL_NEW:  s_mul = cur_reg;
            default:  s_mul = cur_reg;
        endcase
    end

    assign x_mul = cmd.x_use_v ? volt_reg : x_reg;
    assign mul_a = cmd.mul_q ? MUL_A_W'(x_mul) : MUL_A_W'(s_mul);
    assign mul_b = cmd.mul_q ? $signed(MUL_B_W'(leak_reg)) : $signed(MUL_B_W'(gain_reg));
    assign prod  = mul_a * mul_b;

    assign diff   = p_reg - q_reg;
    assign k_next = K_W'(diff >>> FRAC_W);
    assign k_half = cmd.x_half ? (k_reg >>> 1) : k_reg;
    assign x_sum  = SAT_W'(volt_reg) + SAT_W'(k_half);

    assign acc_add  = cmd.k_dbl ? (SUM_W'(k_reg) <<< 1) : SUM_W'(k_reg);
    assign acc_base = cmd.acc_first ? '0 : acc_reg;

    assign abs_acc  = acc_reg[SUM_W-1] ? unsigned'(-acc_reg) : unsigned'(acc_reg);

    // one quotient digit per step, remainder stays below six
    assign dig_val  = {rem_reg, mag_reg[MAG_W-1 -: DIGIT_W]};
    assign dig      = div6_digit(dig_val);
    assign dig_prod = DIG_VAL_W'(dig) * DIG_VAL_W'(RK4_DIVISOR);
    assign rem_next = REM_W'(dig_val - dig_prod);

    assign quo_s   = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign fin_sum = SAT_W'(volt_reg) + SAT_W'(quo_s);
    assign v_new   = sat_volt(fin_sum);
    assign v_spike = (v_new > thresh_reg);

    always_comb
    begin
        volt_next = volt_reg;
        if (last_reg)
            volt_next = '0;
        else if (cmd.finish_step)
            volt_next = v_spike ? '0 : v_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leak_reg   <= LEAK_RESET;
            gain_reg   <= GAIN_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_LEAK:   leak_reg   <= cfg_data[LEAK_W-1:0];
                CFG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_THRESH: thresh_reg <= $signed(cfg_data[THRESH_W-1:0]);
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_reg      <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                volt_reg      <= volt_next;
                prev_reg      <= last_reg ? '0 : cur_reg;
                have_prev_reg <= !last_reg;
            end
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg  <= current_sample;
            last_reg <= last_of_trace;
            mid_reg  <= mid_next;
        end
        if (cmd.mul_p)
            p_reg <= DIFF_W'(prod);
        if (cmd.mul_q)
            q_reg <= DIFF_W'(prod);
        if (cmd.k_calc)
            k_reg <= k_next;
        if (cmd.x_upd)
            x_reg <= sat_volt(x_sum);
        if (cmd.acc_upd)
            acc_reg <= acc_base + acc_add;
        if (cmd.div_init)
        begin
            mag_reg <= MAG_W'(abs_acc);
            neg_reg <= acc_reg[SUM_W-1];
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            mag_reg <= mag_reg << DIGIT_W;
            quo_reg <= {quo_reg[MAG_W-DIGIT_W-1:0], dig};
            rem_reg <= rem_next;
        end
        if (cmd.finish)
        begin
            out_spike_reg <= cmd.finish_step && v_spike;
            out_volt_reg  <= cmd.finish_step ? v_new : volt_reg;
        end
    end

    assign status.have_prev = have_prev_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid        = out_valid_reg;
    assign spike            = out_spike_reg;
    assign membrane_voltage = out_volt_reg;

endmodule

/* rtl/lif_neuron_rk4_spike_top.sv */
// ----------------------------------------------------------------------------
// lif_neuron_rk4_spike_top
// leaky integrate-and-fire neuron, one rk4 step per current sample word
// a stepping word runs four dependent derivatives on the shared multiplier (two
// products each), then the nibble-serial divide by six; the first word of a
// trace is only loaded; in_stall holds off the next word until the result is
// written to the output register
// reset: asynchronous active-low, clears neuron state and loads register defaults
// ----------------------------------------------------------------------------
module lif_neuron_rk4_spike_top
    import lifrk4_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [CFG_IDX_W-1:0]            cfg_index,
    input  logic [CFG_W-1:0]                cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]  current_sample,
    input  logic                            last_of_trace,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            spike,
    output logic signed [VOLTAGE_WIDTH-1:0] membrane_voltage
);

    lifrk4_cmd_t    cmd;
    lifrk4_status_t status;

    lifrk4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lifrk4_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .current_sample   (current_sample),
        .last_of_trace    (last_of_trace),
        .cmd              (cmd),
        .status           (status),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .spike            (spike),
        .membrane_voltage (membrane_voltage)
    );

endmodule
